### rtl/lamp_sound_sequence_controller_macros.svh
// Assertion macros for the lamp and sound sequence controller.
// Used by modules that have clk_i and rst_ni in scope; no other dependencies.
`ifndef LAMP_SOUND_SEQUENCE_CONTROLLER_MACROS_SVH
`define LAMP_SOUND_SEQUENCE_CONTROLLER_MACROS_SVH

`ifndef SYNTH
// Property checked on every clock edge outside reset.
`define LSSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be true outside reset.
`define LSSC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define LSSC_ASSERT(lbl, prop, msg)
`define LSSC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### rtl/lssc_pkg.sv
// Shared types, constants and functions of the lamp and sound sequence controller.
// No dependencies.
package lssc_pkg;

  localparam int unsigned SWITCH_SAMPLES = 12;
  localparam int unsigned RADIO_SAMPLES  = 4;
  localparam logic [5:0]  FADE_STEPS     = 6'd63;

  localparam logic [9:0] LAMP_DELAY_RST = 10'd60;
  localparam logic [9:0] LAMP_DWELL_RST = 10'd24;
  localparam logic [3:0] MAX_CYCLES_RST = 4'd9;
  localparam logic [9:0] EOM_GUARD_RST  = 10'd40;

  typedef enum logic [2:0] {
    CFG_ACC_START_ENABLE = 3'd0,
    CFG_LAMP_DELAY       = 3'd1,
    CFG_LAMP_DWELL       = 3'd2,
    CFG_MAX_CYCLES       = 3'd3,
    CFG_EOM_GUARD        = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VOICE_STOP = 2'd0,
    VOICE_PLAY = 2'd1,
    VOICE_REC  = 2'd2
  } voice_e;

  typedef struct packed {
    logic       acc_start_enable;
    logic [9:0] lamp_delay;
    logic [9:0] lamp_dwell;
    logic [3:0] max_cycles;
    logic [9:0] eom_guard;
  } cfg_t;

  typedef struct packed {
    logic operation;
    logic acc_level;
    logic radio_vt_level;
    logic radio_b_level;
    logic radio_a_level;
    logic stop_switch_level;
    logic play_switch_level;
    logic record_switch_level;
    logic eom_level;
    logic ovf_level;
  } in_item_t;

  // Debounced rising edges, and the held record level, seen on one sample beat.
  typedef struct packed {
    logic acc_rise;
    logic rb_rise;
    logic ra_rise;
    logic stop_rise;
    logic play_rise;
    logic rec_held;
  } events_t;

  typedef struct packed {
    logic        active;
    logic        amp;
    voice_e      voice;
    logic        rec;
    logic [5:0]  fade_step;
    logic [15:0] tick;
    logic [3:0]  cycle;
    logic [7:0]  duty;
  } seq_state_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       amp;
    voice_e     voice;
    logic       active;
    logic       rec;
  } result_t;

  function automatic seq_state_t seq_stop(input seq_state_t s);
    seq_state_t r;
    r           = s;
    r.amp       = 1'b0;
    r.fade_step = '0;
    r.tick      = '0;
    r.duty      = '0;
    r.voice     = VOICE_STOP;
    r.rec       = 1'b0;
    r.active    = 1'b0;
    return r;
  endfunction

  function automatic seq_state_t seq_start(input seq_state_t s, input logic sound,
                                           input logic [9:0] on, input logic [9:0] delay);
    seq_state_t r;
    logic [9:0] lead;
    r    = s;
    lead = on - delay;
    if (sound) begin
      r.amp   = 1'b1;
      r.voice = VOICE_PLAY;
      r.rec   = 1'b0;
    end
    r.fade_step = '0;
    r.tick      = {6'd0, lead};
    r.cycle     = '0;
    r.duty      = '0;
    r.active    = 1'b1;
    return r;
  endfunction

  function automatic seq_state_t seq_toggle(input seq_state_t s, input logic sound,
                                            input logic [9:0] on, input logic [9:0] delay);
    seq_state_t r;
    if (s.active) r = seq_stop(s);
    else          r = seq_start(s, sound, on, delay);
    return r;
  endfunction

  // floor(255 * sin(0.05 * k)) for fade steps 1..62.
  function automatic logic [7:0] sine_duty(input logic [5:0] k);
    logic [7:0] d;
    case (k)
      6'd1:  d = 8'd12;  6'd2:  d = 8'd25;  6'd3:  d = 8'd38;  6'd4:  d = 8'd50;
      6'd5:  d = 8'd63;  6'd6:  d = 8'd75;  6'd7:  d = 8'd87;  6'd8:  d = 8'd99;
      6'd9:  d = 8'd110; 6'd10: d = 8'd122; 6'd11: d = 8'd133; 6'd12: d = 8'd143;
      6'd13: d = 8'd154; 6'd14: d = 8'd164; 6'd15: d = 8'd173; 6'd16: d = 8'd182;
      6'd17: d = 8'd191; 6'd18: d = 8'd199; 6'd19: d = 8'd207; 6'd20: d = 8'd214;
      6'd21: d = 8'd221; 6'd22: d = 8'd227; 6'd23: d = 8'd232; 6'd24: d = 8'd237;
      6'd25: d = 8'd241; 6'd26: d = 8'd245; 6'd27: d = 8'd248; 6'd28: d = 8'd251;
      6'd29: d = 8'd253; 6'd30: d = 8'd254; 6'd31: d = 8'd254; 6'd32: d = 8'd254;
      6'd33: d = 8'd254; 6'd34: d = 8'd252; 6'd35: d = 8'd250; 6'd36: d = 8'd248;
      6'd37: d = 8'd245; 6'd38: d = 8'd241; 6'd39: d = 8'd236; 6'd40: d = 8'd231;
      6'd41: d = 8'd226; 6'd42: d = 8'd220; 6'd43: d = 8'd213; 6'd44: d = 8'd206;
      6'd45: d = 8'd198; 6'd46: d = 8'd190; 6'd47: d = 8'd181; 6'd48: d = 8'd172;
      6'd49: d = 8'd162; 6'd50: d = 8'd152; 6'd51: d = 8'd142; 6'd52: d = 8'd131;
      6'd53: d = 8'd120; 6'd54: d = 8'd108; 6'd55: d = 8'd97;  6'd56: d = 8'd85;
      6'd57: d = 8'd73;  6'd58: d = 8'd61;  6'd59: d = 8'd48;  6'd60: d = 8'd35;
      6'd61: d = 8'd23;  6'd62: d = 8'd10;
      default: d = 8'd0;
    endcase
    return d;
  endfunction

endpackage

### rtl/lssc_debounce.sv
// Input debouncer: sample histories, previous debounced levels and edge detection.
// Depends on lssc_pkg.
module lssc_debounce (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  lssc_pkg::in_item_t item_i,
  input  logic              acc_en_i,
  input  logic              clear_i,
  output lssc_pkg::events_t  events_o
);
  import lssc_pkg::*;

  localparam int unsigned PB_ACC  = 0;
  localparam int unsigned PB_RB   = 1;
  localparam int unsigned PB_RA   = 2;
  localparam int unsigned PB_STOP = 3;
  localparam int unsigned PB_PLAY = 4;

  logic [SWITCH_SAMPLES-1:0] acc_hist_q, acc_hist_d;
  logic [RADIO_SAMPLES-1:0]  rb_hist_q, rb_hist_d;
  logic [RADIO_SAMPLES-1:0]  ra_hist_q, ra_hist_d;
  logic [SWITCH_SAMPLES-1:0] stop_hist_q, stop_hist_d;
  logic [SWITCH_SAMPLES-1:0] play_hist_q, play_hist_d;
  logic [SWITCH_SAMPLES-1:0] rec_hist_q, rec_hist_d;
  logic [4:0]                prev_q, prev_d;

  logic [SWITCH_SAMPLES-1:0] acc_sh, stop_sh, play_sh, rec_sh;
  logic [RADIO_SAMPLES-1:0]  rb_sh, ra_sh;
  logic acc_now, rb_now, ra_now, stop_now, play_now, rec_now;
  logic sample;

  assign sample = step_i && item_i.operation;

  assign acc_sh  = {acc_hist_q[SWITCH_SAMPLES-2:0], item_i.acc_level};
  assign rb_sh   = {rb_hist_q[RADIO_SAMPLES-2:0], item_i.radio_b_level};
  assign ra_sh   = {ra_hist_q[RADIO_SAMPLES-2:0], item_i.radio_a_level};
  assign stop_sh = {stop_hist_q[SWITCH_SAMPLES-2:0], item_i.stop_switch_level};
  assign play_sh = {play_hist_q[SWITCH_SAMPLES-2:0], item_i.play_switch_level};
  assign rec_sh  = {rec_hist_q[SWITCH_SAMPLES-2:0], item_i.record_switch_level};

  // Accessory and radio lines are active high; switches pull low when pressed.
  assign acc_now  = &acc_sh;
  assign rb_now   = &rb_sh;
  assign ra_now   = &ra_sh;
  assign stop_now = ~|stop_sh;
  assign play_now = ~|play_sh;
  assign rec_now  = ~|rec_sh;

  always_comb begin
    events_o.acc_rise  = acc_en_i && acc_now && !prev_q[PB_ACC];
    events_o.rb_rise   = rb_now && !prev_q[PB_RB];
    events_o.ra_rise   = ra_now && !prev_q[PB_RA];
    events_o.stop_rise = stop_now && !prev_q[PB_STOP];
    events_o.play_rise = play_now && !prev_q[PB_PLAY];
    events_o.rec_held  = rec_now;
  end

  always_comb begin
    acc_hist_d  = acc_hist_q;
    rb_hist_d   = rb_hist_q;
    ra_hist_d   = ra_hist_q;
    stop_hist_d = stop_hist_q;
    play_hist_d = play_hist_q;
    rec_hist_d  = rec_hist_q;
    prev_d      = prev_q;
    if (sample) begin
      // The accessory history only runs while accessory start is enabled.
      if (acc_en_i) begin
        acc_hist_d     = acc_sh;
        prev_d[PB_ACC] = acc_now;
      end
      rb_hist_d       = rb_sh;
      ra_hist_d       = ra_sh;
      stop_hist_d     = stop_sh;
      play_hist_d     = play_sh;
      rec_hist_d      = rec_sh;
      prev_d[PB_RB]   = rb_now;
      prev_d[PB_RA]   = ra_now;
      prev_d[PB_STOP] = stop_now;
      prev_d[PB_PLAY] = play_now;
    end
    if (clear_i) begin
      acc_hist_d  = '0;
      rb_hist_d   = '0;
      ra_hist_d   = '0;
      stop_hist_d = '0;
      play_hist_d = '0;
      rec_hist_d  = '0;
      prev_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_hist_q  <= '0;
      rb_hist_q   <= '0;
      ra_hist_q   <= '0;
      stop_hist_q <= '0;
      play_hist_q <= '0;
      rec_hist_q  <= '0;
      prev_q      <= '0;
    end else begin
      acc_hist_q  <= acc_hist_d;
      rb_hist_q   <= rb_hist_d;
      ra_hist_q   <= ra_hist_d;
      stop_hist_q <= stop_hist_d;
      play_hist_q <= play_hist_d;
      rec_hist_q  <= rec_hist_d;
      prev_q      <= prev_d;
    end
  end

endmodule

### rtl/lssc_seq.sv
// Sequence state: lamp fade timing, amplifier, voice mode and record LED.
// Depends on lssc_pkg and the assertion macro header.
module lssc_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  lssc_pkg::in_item_t item_i,
  input  lssc_pkg::cfg_t     cfg_i,
  input  lssc_pkg::events_t  events_i,
  output logic              clear_o,
  output lssc_pkg::result_t  result_o
);
  import lssc_pkg::*;
  `include "lamp_sound_sequence_controller_macros.svh"

  seq_state_t state_q, state_d;
  logic [9:0] on;
  logic [5:0] step_n;

  assign on = (cfg_i.lamp_delay > cfg_i.lamp_dwell) ? cfg_i.lamp_delay : cfg_i.lamp_dwell;

  always_comb begin
    state_d = state_q;
    clear_o = 1'b0;
    step_n  = state_q.fade_step + 6'd1;
    if (step_i) begin
      if (!item_i.operation) begin
        if (state_d.active) begin
          state_d.tick = state_d.tick + 16'd1;
          if (state_d.tick >= {6'd0, on}) begin
            if (step_n >= FADE_STEPS) begin
              state_d.fade_step = '0;
              state_d.duty      = '0;
              state_d.tick      = {6'd0, on - cfg_i.lamp_dwell};
              state_d.cycle     = state_d.cycle + 4'd1;
              if (state_d.cycle >= cfg_i.max_cycles) state_d = seq_stop(state_d);
            end else begin
              state_d.fade_step = step_n;
              state_d.duty      = sine_duty(step_n);
            end
          end
        end
      end else begin
        if (events_i.acc_rise && !state_d.active) begin
          state_d = seq_start(state_d, 1'b1, on, cfg_i.lamp_delay);
        end
        if (events_i.rb_rise) state_d = seq_toggle(state_d, 1'b1, on, cfg_i.lamp_delay);
        if (events_i.ra_rise) state_d = seq_toggle(state_d, 1'b0, on, cfg_i.lamp_delay);
        if (events_i.stop_rise) state_d = seq_stop(state_d);
        if (events_i.play_rise) begin
          // Play pressed while record is held arms the voice chip for recording.
          if (events_i.rec_held) begin
            state_d.voice = VOICE_REC;
            state_d.rec   = 1'b1;
          end else begin
            state_d = seq_toggle(state_d, 1'b1, on, cfg_i.lamp_delay);
          end
        end
        if ((!item_i.eom_level || !item_i.ovf_level) && state_d.voice != VOICE_STOP &&
            state_d.tick > {6'd0, cfg_i.eom_guard}) begin
          state_d = seq_stop(state_d);
        end
      end
      if (!state_d.active && !item_i.acc_level && !item_i.radio_vt_level) begin
        state_d = seq_stop(state_d);
        clear_o = 1'b1;
      end
    end
  end

  always_comb begin
    result_o.duty   = state_d.duty;
    result_o.amp    = state_d.amp;
    result_o.voice  = state_d.voice;
    result_o.active = state_d.active;
    result_o.rec    = state_d.rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  `LSSC_ASSERT(a_duty_only_active, (state_q.duty != 8'd0) |-> state_q.active, "lamp lit while idle")
  `LSSC_ASSERT(a_rec_led_mode, state_q.rec |-> (state_q.voice == VOICE_REC), "record LED without record mode")
  `LSSC_ASSERT(a_idle_cleared, !state_q.active |-> (state_q.tick == 16'd0 && state_q.fade_step == 6'd0), "idle with timing state left")
  `LSSC_ASSERT_NEVER(a_fade_range, state_q.fade_step >= FADE_STEPS, "fade step out of range")

endmodule

### rtl/lamp_sound_sequence_controller.sv
// Lamp and sound sequence controller, top level.
// A beat waits in the input register while the output stalls; then its result is registered.
// Throughput: one beat per cycle without output stalls; the input register refills while the
// result register drains. The single-pass sequence logic between them sets that figure.
// Async reset (rst_ni low) loads register defaults and clears all state but in_q and res_q.
// Depends on lssc_pkg, lssc_debounce, lssc_seq and the assertion macro header.
module lamp_sound_sequence_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       operation_i,
  input  logic       acc_level_i,
  input  logic       radio_vt_level_i,
  input  logic       radio_b_level_i,
  input  logic       radio_a_level_i,
  input  logic       stop_switch_level_i,
  input  logic       play_switch_level_i,
  input  logic       record_switch_level_i,
  input  logic       eom_level_i,
  input  logic       ovf_level_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] lamp_duty_o,
  output logic       amp_on_o,
  output logic [1:0] voice_mode_o,
  output logic       sequence_active_o,
  output logic       record_led_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [9:0] cfg_data_i
);
  import lssc_pkg::*;
  `include "lamp_sound_sequence_controller_macros.svh"

  cfg_t     cfg_q;
  in_item_t in_q;
  logic     in_vld_q;
  logic     out_vld_q;
  result_t  res_q;
  result_t  res_d;
  events_t  events;
  logic     advance;
  logic     clear;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.acc_start_enable <= 1'b0;
      cfg_q.lamp_delay       <= LAMP_DELAY_RST;
      cfg_q.lamp_dwell       <= LAMP_DWELL_RST;
      cfg_q.max_cycles       <= MAX_CYCLES_RST;
      cfg_q.eom_guard        <= EOM_GUARD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ACC_START_ENABLE: cfg_q.acc_start_enable <= cfg_data_i[0];
        CFG_LAMP_DELAY:       cfg_q.lamp_delay       <= cfg_data_i;
        CFG_LAMP_DWELL:       cfg_q.lamp_dwell       <= cfg_data_i;
        CFG_MAX_CYCLES:       cfg_q.max_cycles       <= cfg_data_i[3:0];
        CFG_EOM_GUARD:        cfg_q.eom_guard        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q.operation           <= operation_i;
      in_q.acc_level           <= acc_level_i;
      in_q.radio_vt_level      <= radio_vt_level_i;
      in_q.radio_b_level       <= radio_b_level_i;
      in_q.radio_a_level       <= radio_a_level_i;
      in_q.stop_switch_level   <= stop_switch_level_i;
      in_q.play_switch_level   <= play_switch_level_i;
      in_q.record_switch_level <= record_switch_level_i;
      in_q.eom_level           <= eom_level_i;
      in_q.ovf_level           <= ovf_level_i;
    end
  end

  lssc_debounce u_debounce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .acc_en_i (cfg_q.acc_start_enable),
    .clear_i  (clear),
    .events_o (events)
  );

  lssc_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .events_i (events),
    .clear_o  (clear),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign lamp_duty_o       = res_q.duty;
  assign amp_on_o          = res_q.amp;
  assign voice_mode_o      = res_q.voice;
  assign sequence_active_o = res_q.active;
  assign record_led_o      = res_q.rec;

  `LSSC_ASSERT(a_result_follows, advance |=> out_vld_q, "processed beat produced no result")
  `LSSC_ASSERT(a_input_held, (in_vld_q && !advance) |=> (in_vld_q && $stable(in_q)), "waiting beat lost")
  `LSSC_ASSERT_NEVER(a_clear_idle, clear && res_d.active, "input clear while sequence runs")

endmodule
